### hdl/sbrd_pkg.sv
// ----------------------------------------------------------------------------
// Servo bus receive deframer package
// Shared types and constants for the deframer controller, datapath and top.
// ----------------------------------------------------------------------------
package sbrd_pkg;

    // Framing constants.
    localparam logic [7:0]  HEADER_BYTE     = 8'hFF;
    localparam logic [7:0]  CMD_OFFSET      = 8'h40;
    localparam logic [7:0]  CHECK_MASK      = 8'hFE;
    localparam logic [7:0]  MIN_FRAME_BYTES = 8'd9;
    localparam logic [7:0]  MIN_LENGTH      = 8'd7;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
    localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Bit positions in the error flags.
    localparam int FLAG_TIMEOUT  = 0;
    localparam int FLAG_LENGTH   = 1;
    localparam int FLAG_COMMAND  = 2;
    localparam int FLAG_CHECKSUM = 3;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_ctrl_state;

    // Parse phase of the frame being received.
    typedef enum logic [7:0] {
        PH_HUNT1 = 8'b0000_0001,
        PH_HUNT2 = 8'b0000_0010,
        PH_LEN   = 8'b0000_0100,
        PH_ID    = 8'b0000_1000,
        PH_CMD   = 8'b0001_0000,
        PH_CK1   = 8'b0010_0000,
        PH_CK2   = 8'b0100_0000,
        PH_DATA  = 8'b1000_0000
    } t_phase;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic mem_read;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

### hdl/sbrd_ctrl.sv
// ----------------------------------------------------------------------------
// Servo bus receive deframer controller
// Accepts input beats while idle and sequences the result walk over the
// payload store once a frame closes.
// ----------------------------------------------------------------------------
module sbrd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sbrd_pkg::t_dp_status i_status,
    output sbrd_pkg::t_dp_cmd   o_cmd
);

    sbrd_pkg::t_ctrl_state r_state;
    sbrd_pkg::t_ctrl_state n_state;

    assign o_ready         = (r_state == sbrd_pkg::S_IDLE);
    assign o_cmd.take_item = i_valid && o_ready;
    assign o_cmd.mem_read  = (r_state == sbrd_pkg::S_READ);
    assign o_cmd.load_out  = (r_state == sbrd_pkg::S_LOAD) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbrd_pkg::S_IDLE: begin
                if (o_cmd.take_item && i_status.close) begin
                    n_state = sbrd_pkg::S_READ;
                end
            end
            sbrd_pkg::S_READ: begin
                n_state = sbrd_pkg::S_LOAD;
            end
            sbrd_pkg::S_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.last ? sbrd_pkg::S_IDLE : sbrd_pkg::S_READ;
                end
            end
            default: begin
                n_state = sbrd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbrd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/sbrd_datapath.sv
// ----------------------------------------------------------------------------
// Servo bus receive deframer datapath
// Frame parser registers, checksum, payload store and the result register.
// ----------------------------------------------------------------------------
module sbrd_datapath #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [15:0]           i_cfg_wr_data,
    input  logic                  i_item_kind,
    input  logic [7:0]            i_rx_byte,
    input  sbrd_pkg::t_dp_cmd     i_cmd,
    input  logic                  i_out_ready,
    output sbrd_pkg::t_dp_status  o_status,
    output logic                  o_valid,
    output logic [7:0]            o_frame_id,
    output logic [7:0]            o_command_code,
    output logic [7:0]            o_declared_length,
    output logic [7:0]            o_servo_fault,
    output logic [7:0]            o_servo_detail,
    output logic [3:0]            o_error_flags,
    output logic [7:0]            o_payload_byte,
    output logic [3:0]            o_payload_index,
    output logic                  o_payload_valid,
    output logic                  o_last_of_frame
);

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PAYLOAD);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(MAX_PAYLOAD - 1);

    // Frame being received.
    sbrd_pkg::t_phase r_phase, n_phase;
    logic [7:0]    r_byte_count, n_byte_count;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_id, n_id;
    logic [7:0]    r_cmd, n_cmd;
    logic          r_cmd_err, n_cmd_err;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_ck0, n_ck0;
    logic [7:0]    r_ck1, n_ck1;
    logic [CW-1:0] r_pcount, n_pcount;
    logic [7:0]    r_se, n_se;
    logic [7:0]    r_sd, n_sd;
    logic [15:0]   r_idle, n_idle;
    logic [15:0]   r_timeout;

    // Closed frame, held while its results are walked out.
    logic [7:0]    r_h_id, r_h_cmd, r_h_len, r_h_se, r_h_sd;
    logic [3:0]    r_h_flags;
    logic [CW-1:0] r_h_count;
    logic [AW-1:0] r_k;
    logic [7:0]    r_rd_data;

    logic [7:0]    r_mem [MAX_PAYLOAD];

    logic          w_close, w_timed_out, w_clear, w_count_byte, w_mem_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_eff_len, w_c1, w_c2;
    logic [3:0]    w_flags;
    logic          w_has_status;

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_len        = r_len;
        n_id         = r_id;
        n_cmd        = r_cmd;
        n_cmd_err    = r_cmd_err;
        n_xor        = r_xor;
        n_ck0        = r_ck0;
        n_ck1        = r_ck1;
        n_pcount     = r_pcount;
        n_se         = r_se;
        n_sd         = r_sd;
        n_idle       = r_idle;
        w_close      = 1'b0;
        w_timed_out  = 1'b0;
        w_clear      = 1'b0;
        w_count_byte = 1'b0;
        w_mem_we     = 1'b0;
        w_waddr      = (r_pcount == FULL_COUNT) ? LAST_SLOT : r_pcount[AW-1:0];

        if (i_cmd.take_item) begin
            if (i_item_kind == sbrd_pkg::KIND_TICK) begin
                // Idle ticks only count while a frame is open.
                if (r_phase != sbrd_pkg::PH_HUNT1) begin
                    if (r_idle != sbrd_pkg::IDLE_MAX) begin
                        n_idle = r_idle + 16'd1;
                    end
                    if (n_idle > r_timeout) begin
                        w_close     = 1'b1;
                        w_timed_out = 1'b1;
                    end
                end
            end else begin
                n_idle = '0;
                unique case (r_phase)
                    sbrd_pkg::PH_HUNT1: begin
                        if (i_rx_byte == sbrd_pkg::HEADER_BYTE) begin
                            n_phase      = sbrd_pkg::PH_HUNT2;
                            n_byte_count = 8'd1;
                        end
                    end
                    sbrd_pkg::PH_HUNT2: begin
                        if (i_rx_byte == sbrd_pkg::HEADER_BYTE) begin
                            n_phase      = sbrd_pkg::PH_LEN;
                            n_byte_count = 8'd2;
                        end else begin
                            w_clear = 1'b1;
                        end
                    end
                    sbrd_pkg::PH_LEN: begin
                        n_len        = i_rx_byte;
                        n_xor        = i_rx_byte;
                        n_phase      = sbrd_pkg::PH_ID;
                        w_count_byte = 1'b1;
                    end
                    sbrd_pkg::PH_ID: begin
                        n_id         = i_rx_byte;
                        n_xor        = r_xor ^ i_rx_byte;
                        n_phase      = sbrd_pkg::PH_CMD;
                        w_count_byte = 1'b1;
                    end
                    sbrd_pkg::PH_CMD: begin
                        if (i_rx_byte > sbrd_pkg::CMD_OFFSET) begin
                            n_cmd = i_rx_byte - sbrd_pkg::CMD_OFFSET;
                        end else begin
                            n_cmd     = i_rx_byte;
                            n_cmd_err = 1'b1;
                        end
                        n_xor        = r_xor ^ i_rx_byte;
                        n_phase      = sbrd_pkg::PH_CK1;
                        w_count_byte = 1'b1;
                    end
                    sbrd_pkg::PH_CK1: begin
                        n_ck0        = i_rx_byte;
                        n_phase      = sbrd_pkg::PH_CK2;
                        w_count_byte = 1'b1;
                    end
                    sbrd_pkg::PH_CK2: begin
                        n_ck1        = i_rx_byte;
                        n_phase      = sbrd_pkg::PH_DATA;
                        w_count_byte = 1'b1;
                    end
                    sbrd_pkg::PH_DATA: begin
                        w_mem_we = 1'b1;
                        // Once full, the last slot is overwritten, so the
                        // second to last byte stays where it was.
                        if (r_pcount != FULL_COUNT) begin
                            n_pcount = r_pcount + CW'(1);
                            n_se     = r_sd;
                        end
                        n_sd         = i_rx_byte;
                        n_xor        = r_xor ^ i_rx_byte;
                        w_count_byte = 1'b1;
                    end
                    default: begin
                        w_clear = 1'b1;
                    end
                endcase
                if (w_count_byte) begin
                    n_byte_count = r_byte_count + 8'd1;
                    if (n_byte_count >= w_eff_len) begin
                        w_close = 1'b1;
                    end
                end
            end
        end
    end

    assign w_eff_len = (n_len < sbrd_pkg::MIN_LENGTH) ? sbrd_pkg::MIN_LENGTH : n_len;
    assign w_c1      = n_xor & sbrd_pkg::CHECK_MASK;
    assign w_c2      = (~w_c1) & sbrd_pkg::CHECK_MASK;
    assign w_has_status = (n_pcount >= CW'(2));

    always_comb begin
        w_flags                          = '0;
        w_flags[sbrd_pkg::FLAG_TIMEOUT]  = w_timed_out;
        w_flags[sbrd_pkg::FLAG_LENGTH]   = w_timed_out ||
                                           (n_byte_count < sbrd_pkg::MIN_FRAME_BYTES);
        w_flags[sbrd_pkg::FLAG_COMMAND]  = n_cmd_err;
        w_flags[sbrd_pkg::FLAG_CHECKSUM] = (n_ck0 != w_c1) || (n_ck1 != w_c2);
    end

    assign o_status.close    = w_close;
    assign o_status.last     = (r_h_count == '0) || ((CW'(r_k) + CW'(1)) == r_h_count);
    assign o_status.out_free = !o_valid || i_out_ready;

    // Frame state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sbrd_pkg::PH_HUNT1;
            r_byte_count <= '0;
            r_len        <= '0;
            r_id         <= '0;
            r_cmd        <= '0;
            r_cmd_err    <= 1'b0;
            r_xor        <= '0;
            r_ck0        <= '0;
            r_ck1        <= '0;
            r_pcount     <= '0;
            r_se         <= '0;
            r_sd         <= '0;
            r_idle       <= '0;
            r_timeout    <= sbrd_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (w_close || w_clear) begin
                r_phase      <= sbrd_pkg::PH_HUNT1;
                r_byte_count <= '0;
                r_len        <= '0;
                r_id         <= '0;
                r_cmd        <= '0;
                r_cmd_err    <= 1'b0;
                r_xor        <= '0;
                r_ck0        <= '0;
                r_ck1        <= '0;
                r_pcount     <= '0;
                r_se         <= '0;
                r_sd         <= '0;
                r_idle       <= '0;
            end else begin
                r_phase      <= n_phase;
                r_byte_count <= n_byte_count;
                r_len        <= n_len;
                r_id         <= n_id;
                r_cmd        <= n_cmd;
                r_cmd_err    <= n_cmd_err;
                r_xor        <= n_xor;
                r_ck0        <= n_ck0;
                r_ck1        <= n_ck1;
                r_pcount     <= n_pcount;
                r_se         <= n_se;
                r_sd         <= n_sd;
                r_idle       <= n_idle;
            end
        end
    end

    // Snapshot of the closed frame and the walk index.
    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_h_id    <= n_id;
            r_h_cmd   <= n_cmd;
            r_h_len   <= n_len;
            r_h_se    <= w_has_status ? n_se : 8'd0;
            r_h_sd    <= w_has_status ? n_sd : 8'd0;
            r_h_flags <= w_flags;
            r_h_count <= n_pcount;
            r_k       <= '0;
        end else if (i_cmd.load_out && !o_status.last) begin
            r_k <= r_k + AW'(1);
        end
    end

    // Payload store.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= i_rx_byte;
        end
        if (i_cmd.mem_read) begin
            r_rd_data <= r_mem[r_k];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_frame_id        <= r_h_id;
            o_command_code    <= r_h_cmd;
            o_declared_length <= r_h_len;
            o_servo_fault     <= r_h_se;
            o_servo_detail    <= r_h_sd;
            o_error_flags     <= r_h_flags;
            o_payload_byte    <= (r_h_count != '0) ? r_rd_data : 8'd0;
            o_payload_index   <= 4'(r_k);
            o_payload_valid   <= (r_h_count != '0);
            o_last_of_frame   <= o_status.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_valid <= 1'b0;
        end
    end

endmodule

### hdl/servo_bus_rx_deframer.sv
// ----------------------------------------------------------------------------
// Servo bus receive deframer
// Parses header, length, id, command, check and data bytes of servo bus frames
// and reports each closed frame as one beat per stored data byte (one if none).
// ----------------------------------------------------------------------------
// A received byte or idle tick is taken while the block is idle. An item that
// closes a frame (byte count reaching the declared length, or 7 if that is less,
// or idle ticks exceeding the timeout, 1000 after reset, else i_cfg_wr_data as
// last written) then occupies the block with a read and a load state per result
// beat, max(stored data bytes, 1) beats, while each stored byte is read from the
// single-port payload store and loaded into the output register; output
// back-pressure adds to that. The next item is taken as soon as the last beat of
// a frame sits in the output register. No clearing pass follows reset.
module servo_bus_rx_deframer #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_item_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_id,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_declared_length,
    output logic [7:0]  o_servo_fault,
    output logic [7:0]  o_servo_detail,
    output logic [3:0]  o_error_flags,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_payload_index,
    output logic        o_payload_valid,
    output logic        o_last_of_frame
);

    sbrd_pkg::t_dp_cmd    w_cmd;
    sbrd_pkg::t_dp_status w_status;

    sbrd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    sbrd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_item_kind       (i_item_kind),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (w_cmd),
        .i_out_ready       (i_ready),
        .o_status          (w_status),
        .o_valid           (o_valid),
        .o_frame_id        (o_frame_id),
        .o_command_code    (o_command_code),
        .o_declared_length (o_declared_length),
        .o_servo_fault     (o_servo_fault),
        .o_servo_detail    (o_servo_detail),
        .o_error_flags     (o_error_flags),
        .o_payload_byte    (o_payload_byte),
        .o_payload_index   (o_payload_index),
        .o_payload_valid   (o_payload_valid),
        .o_last_of_frame   (o_last_of_frame)
    );

`ifndef ASSERT_OFF
    // A result beat is only loaded when the output register is free.
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_valid || i_ready))
        else $error("result loaded over a beat still waiting");

    // A beat without a data byte is always the final one of its frame.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_payload_valid) |-> o_last_of_frame)
        else $error("data-less result beat not marked last");

    // Once a frame closes, no input is taken until its results are out.
    a_close_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.take_item && w_status.close) |=> !o_ready)
        else $error("input accepted directly after a frame closed");

    // Store reads happen only while walking results, never with an input beat.
    a_read_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mem_read |-> !o_ready)
        else $error("payload read while input is being accepted");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo bus receive deframer testbench
// Drives received bytes and idle ticks into the deframer over a valid/ready
// channel and predicts every result beat of each closed frame. Result beats
// are checked field by field against the predicted queue. The tests cover
// header hunting, command and checksum errors, short frames, idle timeouts,
// the full payload store, back-pressure and the largest timeout.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_PAYLOAD = 16;
    // A closing item walks the store with a read and a load state per beat.
    localparam int SETTLE_CYCLES = 2 * MAX_PAYLOAD + 8;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] frame_id;
        logic [7:0] command_code;
        logic [7:0] declared_length;
        logic [7:0] servo_fault;
        logic [7:0] servo_detail;
        logic [3:0] error_flags;
        logic [7:0] payload_byte;
        logic [3:0] payload_index;
        logic       payload_valid;
        logic       last_of_frame;
    } t_frame_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_item_kind;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_frame_id;
    logic [7:0]  o_command_code;
    logic [7:0]  o_declared_length;
    logic [7:0]  o_servo_fault;
    logic [7:0]  o_servo_detail;
    logic [3:0]  o_error_flags;
    logic [7:0]  o_payload_byte;
    logic [3:0]  o_payload_index;
    logic        o_payload_valid;
    logic        o_last_of_frame;

    // Predicted deframer state.
    sbrd_pkg::t_phase rx_phase;
    logic [7:0]  frame_bytes;
    logic [7:0]  len_byte;
    logic [7:0]  id_byte;
    logic [7:0]  cmd_byte;
    logic [7:0]  running_xor;
    logic [7:0]  sum_byte_lo;
    logic [7:0]  sum_byte_hi;
    logic [7:0]  data_store [MAX_PAYLOAD];
    int          data_count;
    logic [3:0]  frame_flags;
    logic [15:0] idle_ticks;
    logic [15:0] timeout_ticks;

    t_frame_beat beat_q [$];
    int          mismatch_count;
    int          items_taken;
    int          hold_cycles;
    int          stall_left;
    bit          idling_on;
    int          tick_pct;

    servo_bus_rx_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_item_kind       (i_item_kind),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_frame_id        (o_frame_id),
        .o_command_code    (o_command_code),
        .o_declared_length (o_declared_length),
        .o_servo_fault     (o_servo_fault),
        .o_servo_detail    (o_servo_detail),
        .o_error_flags     (o_error_flags),
        .o_payload_byte    (o_payload_byte),
        .o_payload_index   (o_payload_index),
        .o_payload_valid   (o_payload_valid),
        .o_last_of_frame   (o_last_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idling_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_frame();
        rx_phase    = sbrd_pkg::PH_HUNT1;
        frame_bytes = '0;
        len_byte    = '0;
        id_byte     = '0;
        cmd_byte    = '0;
        running_xor = '0;
        sum_byte_lo = '0;
        sum_byte_hi = '0;
        data_count  = 0;
        frame_flags = '0;
        idle_ticks  = '0;
    endfunction

    function automatic void close_frame(logic timed_out);
        logic [7:0]  sum_lo;
        logic [7:0]  sum_hi;
        logic [7:0]  st_err;
        logic [7:0]  st_det;
        logic [3:0]  flags;
        int          beats;
        t_frame_beat beat;
        flags  = frame_flags;
        sum_lo = running_xor & sbrd_pkg::CHECK_MASK;
        sum_hi = ~sum_lo & sbrd_pkg::CHECK_MASK;
        if (timed_out) begin
            flags[sbrd_pkg::FLAG_TIMEOUT] = 1'b1;
            flags[sbrd_pkg::FLAG_LENGTH]  = 1'b1;
        end
        if (frame_bytes < sbrd_pkg::MIN_FRAME_BYTES) begin
            flags[sbrd_pkg::FLAG_LENGTH] = 1'b1;
        end
        if (sum_byte_lo != sum_lo || sum_byte_hi != sum_hi) begin
            flags[sbrd_pkg::FLAG_CHECKSUM] = 1'b1;
        end
        st_err = '0;
        st_det = '0;
        if (data_count >= 2) begin
            st_err = data_store[data_count - 2];
            st_det = data_store[data_count - 1];
        end
        beats = (data_count == 0) ? 1 : data_count;
        for (int k = 0; k < beats; k++) begin
            beat.frame_id        = id_byte;
            beat.command_code    = cmd_byte;
            beat.declared_length = len_byte;
            beat.servo_fault     = st_err;
            beat.servo_detail    = st_det;
            beat.error_flags     = flags;
            beat.payload_byte    = (data_count != 0) ? data_store[k] : 8'h00;
            beat.payload_index   = 4'(k);
            beat.payload_valid   = (data_count != 0);
            beat.last_of_frame   = (k + 1 == beats);
            beat_q.push_back(beat);
        end
        clear_frame();
    endfunction

    function automatic void predict_item(logic kind, logic [7:0] b);
        logic counted;
        counted = 1'b0;
        if (kind == sbrd_pkg::KIND_TICK) begin
            // Ticks only count while a frame is open.
            if (rx_phase != sbrd_pkg::PH_HUNT1) begin
                if (idle_ticks != sbrd_pkg::IDLE_MAX) begin
                    idle_ticks++;
                end
                if (idle_ticks > timeout_ticks) begin
                    close_frame(1'b1);
                end
            end
        end else begin
            idle_ticks = '0;
            counted    = 1'b1;
            case (rx_phase)
                sbrd_pkg::PH_HUNT1: begin
                    counted = 1'b0;
                    if (b == sbrd_pkg::HEADER_BYTE) begin
                        rx_phase    = sbrd_pkg::PH_HUNT2;
                        frame_bytes = 8'd1;
                    end
                end
                sbrd_pkg::PH_HUNT2: begin
                    counted = 1'b0;
                    if (b == sbrd_pkg::HEADER_BYTE) begin
                        rx_phase    = sbrd_pkg::PH_LEN;
                        frame_bytes = 8'd2;
                    end else begin
                        clear_frame();
                    end
                end
                sbrd_pkg::PH_LEN: begin
                    len_byte    = b;
                    running_xor = b;
                    rx_phase    = sbrd_pkg::PH_ID;
                end
                sbrd_pkg::PH_ID: begin
                    id_byte     = b;
                    running_xor = running_xor ^ b;
                    rx_phase    = sbrd_pkg::PH_CMD;
                end
                sbrd_pkg::PH_CMD: begin
                    if (b > sbrd_pkg::CMD_OFFSET) begin
                        cmd_byte = b - sbrd_pkg::CMD_OFFSET;
                    end else begin
                        cmd_byte = b;
                        frame_flags[sbrd_pkg::FLAG_COMMAND] = 1'b1;
                    end
                    running_xor = running_xor ^ b;
                    rx_phase    = sbrd_pkg::PH_CK1;
                end
                sbrd_pkg::PH_CK1: begin
                    sum_byte_lo = b;
                    rx_phase    = sbrd_pkg::PH_CK2;
                end
                sbrd_pkg::PH_CK2: begin
                    sum_byte_hi = b;
                    rx_phase    = sbrd_pkg::PH_DATA;
                end
                default: begin
                    // Once the store is full the last slot keeps being overwritten.
                    if (data_count < MAX_PAYLOAD) begin
                        data_store[data_count] = b;
                        data_count++;
                    end else begin
                        data_store[MAX_PAYLOAD - 1] = b;
                    end
                    running_xor = running_xor ^ b;
                end
            endcase
            if (counted) begin
                frame_bytes++;
                if (frame_bytes >= ((len_byte < sbrd_pkg::MIN_LENGTH) ? sbrd_pkg::MIN_LENGTH
                                                                      : len_byte)) begin
                    close_frame(1'b0);
                end
            end
        end
    endfunction

    function automatic void check_beat(t_frame_beat got, t_frame_beat want);
        string diff;
        diff = "";
        if (got.frame_id !== want.frame_id)
            diff = {diff, $sformatf(" frame_id %h/%h", want.frame_id, got.frame_id)};
        if (got.command_code !== want.command_code)
            diff = {diff, $sformatf(" command_code %h/%h", want.command_code,
                                    got.command_code)};
        if (got.declared_length !== want.declared_length)
            diff = {diff, $sformatf(" declared_length %h/%h", want.declared_length,
                                    got.declared_length)};
        if (got.servo_fault !== want.servo_fault)
            diff = {diff, $sformatf(" servo_fault %h/%h", want.servo_fault,
                                    got.servo_fault)};
        if (got.servo_detail !== want.servo_detail)
            diff = {diff, $sformatf(" servo_detail %h/%h", want.servo_detail,
                                    got.servo_detail)};
        if (got.error_flags !== want.error_flags)
            diff = {diff, $sformatf(" error_flags %b/%b", want.error_flags, got.error_flags)};
        if (got.payload_byte !== want.payload_byte)
            diff = {diff, $sformatf(" payload_byte %h/%h", want.payload_byte,
                                    got.payload_byte)};
        if (got.payload_index !== want.payload_index)
            diff = {diff, $sformatf(" payload_index %0d/%0d", want.payload_index,
                                    got.payload_index)};
        if (got.payload_valid !== want.payload_valid)
            diff = {diff, $sformatf(" payload_valid %b/%b", want.payload_valid,
                                    got.payload_valid)};
        if (got.last_of_frame !== want.last_of_frame)
            diff = {diff, $sformatf(" last_of_frame %b/%b", want.last_of_frame,
                                    got.last_of_frame)};
        if (diff != "") begin
            note_mismatch({"beat mismatch (expected/actual):", diff});
        end
    endfunction

    // Result checker: every accepted beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_frame_beat got;
        if (i_rst_n && o_valid && i_ready) begin
            got.frame_id        = o_frame_id;
            got.command_code    = o_command_code;
            got.declared_length = o_declared_length;
            got.servo_fault     = o_servo_fault;
            got.servo_detail    = o_servo_detail;
            got.error_flags     = o_error_flags;
            got.payload_byte    = o_payload_byte;
            got.payload_index   = o_payload_index;
            got.payload_valid   = o_payload_valid;
            got.last_of_frame   = o_last_of_frame;
            if (beat_q.size() == 0) begin
                note_mismatch($sformatf("unexpected beat, frame_id %h", o_frame_id));
            end else begin
                check_beat(got, beat_q.pop_front());
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    initial begin
        i_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else begin
                i_ready    = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item_kind = kind;
        i_rx_byte   = data;
        i_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (kind == sbrd_pkg::KIND_BYTE || rx_phase != sbrd_pkg::PH_HUNT1) begin
            items_taken++;
        end
        predict_item(kind, data);
    endtask

    // Lowers valid after the last beat and waits for every predicted result.
    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (beat_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (beat_q.size() != 0) begin
            note_mismatch($sformatf("%0d predicted beats never arrived", beat_q.size()));
        end
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = ticks;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        timeout_ticks = ticks;
    endtask

    // Sends the first keep bytes of a frame (all of it when keep is negative or beyond its length).
    task automatic send_frame(input logic [7:0] len, input logic [7:0] id,
                              input logic [7:0] cmd, input bit good_sum, input int keep);
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] b;
        int         n_data;
        int         n_send;
        n_data = int'((len < sbrd_pkg::MIN_LENGTH) ? sbrd_pkg::MIN_LENGTH : len)
                 - int'(sbrd_pkg::MIN_LENGTH);
        sum    = len ^ id ^ cmd;
        body.delete();
        body.push_back(sbrd_pkg::HEADER_BYTE);
        body.push_back(sbrd_pkg::HEADER_BYTE);
        body.push_back(len);
        body.push_back(id);
        body.push_back(cmd);
        body.push_back(8'h00);
        body.push_back(8'h00);
        repeat (n_data) begin
            b = 8'($urandom);
            body.push_back(b);
            sum = sum ^ b;
        end
        body[5] = sum & sbrd_pkg::CHECK_MASK;
        body[6] = ~(sum & sbrd_pkg::CHECK_MASK) & sbrd_pkg::CHECK_MASK;
        if (!good_sum) begin
            body[5 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        end
        n_send = (keep < 0 || keep > body.size()) ? body.size() : keep;
        for (int i = 0; i < n_send; i++) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                send_item(sbrd_pkg::KIND_TICK, 8'($urandom));
            end
            send_item(sbrd_pkg::KIND_BYTE, body[i]);
        end
    endtask

    // Strays, a header restart, ticks outside a frame, then a frame held open
    // by idle ticks well below the reset timeout and finished by its bytes.
    task automatic test_reset_timeout();
        send_item(sbrd_pkg::KIND_BYTE, 8'h00);
        send_item(sbrd_pkg::KIND_BYTE, 8'h55);
        send_item(sbrd_pkg::KIND_BYTE, sbrd_pkg::HEADER_BYTE);
        send_item(sbrd_pkg::KIND_BYTE, 8'h12);
        send_item(sbrd_pkg::KIND_TICK, 8'hFF);
        send_item(sbrd_pkg::KIND_TICK, 8'h00);
        send_item(sbrd_pkg::KIND_BYTE, sbrd_pkg::HEADER_BYTE);
        send_item(sbrd_pkg::KIND_BYTE, sbrd_pkg::HEADER_BYTE);
        repeat (40) send_item(sbrd_pkg::KIND_TICK, 8'($urandom));
        send_item(sbrd_pkg::KIND_BYTE, 8'd9);
        repeat (6) send_item(sbrd_pkg::KIND_BYTE, 8'($urandom));
        wait_drained();
    endtask

    task automatic test_directed_frames();
        write_timeout(16'd1);
        send_frame(8'd9, 8'h01, 8'h41, 1'b1, -1);
        send_frame(8'd7, 8'hFE, sbrd_pkg::CMD_OFFSET, 1'b1, -1);
        send_frame(8'd0, 8'h00, 8'h00, 1'b0, -1);
        send_frame(8'd12, 8'h7F, 8'hFF, 1'b0, -1);
        send_frame(8'd25, 8'hA5, 8'h47, 1'b1, -1);
        // Truncated after the check bytes; two ticks exceed a timeout of one.
        send_frame(8'd10, 8'h22, 8'h55, 1'b1, 7);
        send_item(sbrd_pkg::KIND_TICK, 8'h00);
        send_item(sbrd_pkg::KIND_TICK, 8'hFF);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_timeout(16'd200);
        idling_on   = 1'b0;
        hold_cycles = 400;
        repeat (4) send_frame(8'd14, 8'($urandom), 8'h43, 1'b1, -1);
        wait_drained();
        idling_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int         start;
        int         pick;
        int         keep;
        int         span;
        logic [7:0] len;
        logic [7:0] cmd;
        tick_pct = 4;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       write_timeout(16'd3);
                1:       write_timeout(16'($urandom_range(1, 40)));
                2:       write_timeout(16'd1);
                3:       write_timeout(sbrd_pkg::IDLE_MAX);
                default: write_timeout(16'($urandom_range(2, 12)));
            endcase
            idling_on = (p != 2);
            start     = items_taken;
            while (items_taken - start < 55) begin
                case ($urandom_range(0, 9))
                    0:       len = 8'($urandom_range(0, 6));
                    1:       len = 8'($urandom_range(25, 40));
                    default: len = 8'($urandom_range(7, 20));
                endcase
                cmd  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 64))
                                                   : 8'($urandom);
                span = int'((len < sbrd_pkg::MIN_LENGTH) ? sbrd_pkg::MIN_LENGTH : len);
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame(len, 8'($urandom), cmd, $urandom_range(0, 4) != 0, -1);
                end else if (pick < 82) begin
                    keep = $urandom_range(1, span - 1);
                    send_frame(len, 8'($urandom), cmd, 1'b1, keep);
                    if (timeout_ticks <= 16'd64) begin
                        repeat (int'(timeout_ticks) + 1) begin
                            send_item(sbrd_pkg::KIND_TICK, 8'($urandom));
                        end
                    end
                end else if (pick < 92) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(sbrd_pkg::KIND_BYTE,
                                  $urandom_range(0, 1) ? sbrd_pkg::HEADER_BYTE
                                                       : 8'($urandom));
                    end
                end else begin
                    repeat ($urandom_range(1, 5)) send_item(sbrd_pkg::KIND_TICK, 8'($urandom));
                end
            end
        end
        tick_pct  = 0;
        idling_on = 1'b1;
        wait_drained();
    endtask

    // With the largest timeout a run of ticks never closes the open frame.
    task automatic test_max_timeout();
        write_timeout(sbrd_pkg::IDLE_MAX);
        idling_on = 1'b0;
        send_frame(8'd9, 8'($urandom), 8'h50, 1'b1, 8);
        repeat (60) send_item(sbrd_pkg::KIND_TICK, 8'($urandom));
        send_item(sbrd_pkg::KIND_BYTE, 8'($urandom));
        idling_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = sbrd_pkg::TIMEOUT_RESET;
        i_valid        = 1'b0;
        i_item_kind    = sbrd_pkg::KIND_BYTE;
        i_rx_byte      = 8'h00;
        mismatch_count = 0;
        items_taken    = 0;
        hold_cycles    = 0;
        idling_on      = 1'b1;
        tick_pct       = 0;
        timeout_ticks  = sbrd_pkg::TIMEOUT_RESET;
        clear_frame();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_timeout();
        test_directed_frames();
        test_backpressure();
        test_random_traffic();
        test_max_timeout();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && beat_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
